>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the preamble inserter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OPI_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("opi assertion failed: name");

// A condition that must hold in the cycle after the trigger.
`define OPI_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("opi assertion failed: name");

`endif

>>> hw/rtl/opi_pkg.sv
// Package with the types and constants of the preamble inserter.
`default_nettype none

package opi_pkg;

    // Sequencer modes.
    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_PRE  = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUB    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd5;

    localparam int CFG_DATA_W = 64;
    localparam int NSUB_W     = 7;
    localparam int REP_W      = 5;
    localparam int REP_IDX_W  = 4;
    localparam int FRAME_W    = 16;
    localparam int AMP_W      = 15;
    localparam int MAX_REPEAT = 16;

    // Effective scalar settings, already clamped to their legal ranges.
    typedef struct packed {
        logic [NSUB_W-1:0]  num_sub;
        logic [REP_W-1:0]   rep_count;
        logic [FRAME_W-1:0] frame_len;
        logic [AMP_W-1:0]   amp;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/opi_cfg_regs.sv
// Configuration registers of the preamble inserter, stored already clamped.
`default_nettype none

module opi_cfg_regs #(
    parameter int MAX_SUBCARRIERS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [opi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [opi_pkg::CFG_DATA_W-1:0]      cfg_data,
    output opi_pkg::cfg_t                            cfg,
    output logic [MAX_SUBCARRIERS-1:0]               pilot_mask,
    output logic [MAX_SUBCARRIERS-1:0]               sign_mask
);

    localparam logic [opi_pkg::NSUB_W-1:0] NSUB_MAX = opi_pkg::NSUB_W'(MAX_SUBCARRIERS);
    localparam logic [opi_pkg::NSUB_W-1:0] NSUB_RESET =
        (MAX_SUBCARRIERS < 64) ? opi_pkg::NSUB_W'(MAX_SUBCARRIERS) : opi_pkg::NSUB_W'(64);
    localparam logic [opi_pkg::REP_W-1:0] REP_MAX = opi_pkg::REP_W'(opi_pkg::MAX_REPEAT);

    opi_pkg::cfg_t                cfg_reg;
    logic [MAX_SUBCARRIERS-1:0]   pilot_mask_reg;
    logic [MAX_SUBCARRIERS-1:0]   sign_mask_reg;

    logic [opi_pkg::NSUB_W-1:0]   nsub_wr;
    logic [opi_pkg::REP_W-1:0]    rep_wr;
    logic [opi_pkg::FRAME_W-1:0]  frame_wr;

    // Clamp the written values so the sequencer sees legal settings only.
    always_comb
    begin
        nsub_wr = cfg_data[opi_pkg::NSUB_W-1:0];
        if (nsub_wr == '0)
        begin
            nsub_wr = opi_pkg::NSUB_W'(1);
        end
        else if (nsub_wr > NSUB_MAX)
        begin
            nsub_wr = NSUB_MAX;
        end

        rep_wr = cfg_data[opi_pkg::REP_W-1:0];
        if (rep_wr == '0)
        begin
            rep_wr = opi_pkg::REP_W'(1);
        end
        else if (rep_wr > REP_MAX)
        begin
            rep_wr = REP_MAX;
        end

        frame_wr = cfg_data[opi_pkg::FRAME_W-1:0];
        if (frame_wr == '0)
        begin
            frame_wr = opi_pkg::FRAME_W'(1);
        end
    end

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_sub   <= NSUB_RESET;
            cfg_reg.rep_count <= opi_pkg::REP_W'(1);
            cfg_reg.frame_len <= opi_pkg::FRAME_W'(480);
            cfg_reg.amp       <= opi_pkg::AMP_W'(8192);
            pilot_mask_reg    <= '0;
            sign_mask_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                opi_pkg::CFG_NUM_SUB:    cfg_reg.num_sub   <= nsub_wr;
                opi_pkg::CFG_REPEAT:     cfg_reg.rep_count <= rep_wr;
                opi_pkg::CFG_FRAME:      cfg_reg.frame_len <= frame_wr;
                opi_pkg::CFG_PILOT_MASK: pilot_mask_reg    <= cfg_data[MAX_SUBCARRIERS-1:0];
                opi_pkg::CFG_SIGN_MASK:  sign_mask_reg     <= cfg_data[MAX_SUBCARRIERS-1:0];
                opi_pkg::CFG_AMPLITUDE:  cfg_reg.amp       <= cfg_data[opi_pkg::AMP_W-1:0];
                default:                 ;
            endcase
        end
    end

    assign cfg        = cfg_reg;
    assign pilot_mask = pilot_mask_reg;
    assign sign_mask  = sign_mask_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ofdm_preamble_inserter.sv
// The result item of an accepted tick is in the output register in the following cycle.
// One tick per cycle while tick_stall is low; the mode sequencer updates on every accepted tick.
// Ticks are stalled only while the output register holds an item that is stalled.
// Reset (rst_n, asynchronous, active low) returns to waiting with all counters
// cleared and the configuration registers at their default values.
`default_nettype none
`include "assert_macros.svh"

module ofdm_preamble_inserter #(
    parameter int MAX_SUBCARRIERS = 64,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [opi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [opi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Tick channel.
    input  wire logic                               tick_valid,
    output logic                                    tick_stall,
    input  wire logic                               sample_present,
    input  wire logic                               second_present,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_imag,
    // Result channel.
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic                                    out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]          out_real,
    output logic signed [SAMPLE_WIDTH-1:0]          out_imag,
    output logic                                    sample_taken,
    output logic                                    in_preamble
);

    localparam int TONE_W = $clog2(MAX_SUBCARRIERS);
    localparam int WIDE_W = 32;

    opi_pkg::cfg_t                 cfg;
    logic [MAX_SUBCARRIERS-1:0]    pilot_mask;
    logic [MAX_SUBCARRIERS-1:0]    sign_mask;

    opi_pkg::mode_t                mode_reg, mode_next;
    logic [TONE_W-1:0]             tone_reg, tone_next;
    logic [opi_pkg::REP_IDX_W-1:0] rep_reg, rep_next;
    logic [opi_pkg::FRAME_W-1:0]   count_reg, count_next;

    logic                          result_valid_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]       out_real_reg, out_real_next;
    logic [SAMPLE_WIDTH-1:0]       out_imag_reg, out_imag_next;
    logic                          taken_reg, taken_next;
    logic                          pre_reg, pre_next;

    logic                          tick_fire;
    logic [opi_pkg::NSUB_W-1:0]    tone_plus;
    logic [opi_pkg::REP_W-1:0]     rep_plus;
    logic [opi_pkg::FRAME_W-1:0]   count_plus;
    logic [WIDE_W-1:0]             amp_ext;
    logic [WIDE_W-1:0]             tone_val;

    opi_cfg_regs #(
        .MAX_SUBCARRIERS (MAX_SUBCARRIERS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .pilot_mask (pilot_mask),
        .sign_mask  (sign_mask)
    );

    // A tick is taken unless a finished item is waiting on a stalled output.
    assign tick_stall = result_valid_reg && result_stall;
    assign tick_fire  = tick_valid && !tick_stall;

    assign tone_plus  = opi_pkg::NSUB_W'(tone_reg) + opi_pkg::NSUB_W'(1);
    assign rep_plus   = opi_pkg::REP_W'(rep_reg) + opi_pkg::REP_W'(1);
    assign count_plus = count_reg + opi_pkg::FRAME_W'(1);

    // Preamble tone value: the pilot amplitude, negated where the sign bit is set.
    assign amp_ext  = WIDE_W'(cfg.amp);
    assign tone_val = sign_mask[tone_reg] ? (WIDE_W'(0) - amp_ext) : amp_ext;

    // Mode sequencer and result formation for one tick.
    always_comb
    begin
        mode_next      = mode_reg;
        tone_next      = tone_reg;
        rep_next       = rep_reg;
        count_next     = count_reg;
        out_valid_next = 1'b0;
        out_real_next  = '0;
        out_imag_next  = '0;
        taken_next     = 1'b0;
        pre_next       = 1'b0;

        case (mode_reg)
            opi_pkg::MODE_PRE:
            begin
                out_valid_next = 1'b1;
                pre_next       = 1'b1;
                if (pilot_mask[tone_reg])
                begin
                    out_real_next = tone_val[SAMPLE_WIDTH-1:0];
                end
                if (tone_plus >= cfg.num_sub)
                begin
                    tone_next = '0;
                    if (rep_plus >= cfg.rep_count)
                    begin
                        rep_next   = '0;
                        count_next = '0;
                        mode_next  = opi_pkg::MODE_DATA;
                    end
                    else
                    begin
                        rep_next = rep_plus[opi_pkg::REP_IDX_W-1:0];
                    end
                end
                else
                begin
                    tone_next = tone_plus[TONE_W-1:0];
                end
            end
            opi_pkg::MODE_DATA:
            begin
                if (sample_present)
                begin
                    out_valid_next = 1'b1;
                    taken_next     = 1'b1;
                    out_real_next  = sample_real;
                    out_imag_next  = sample_imag;
                    count_next     = count_plus;
                    if (count_plus >= cfg.frame_len)
                    begin
                        count_next = '0;
                        tone_next  = '0;
                        rep_next   = '0;
                        mode_next  = second_present ? opi_pkg::MODE_PRE : opi_pkg::MODE_WAIT;
                    end
                end
            end
            default:
            begin
                // Waiting, and the unused code, wait for the first sample.
                mode_next = opi_pkg::MODE_WAIT;
                if (sample_present)
                begin
                    tone_next = '0;
                    rep_next  = '0;
                    mode_next = opi_pkg::MODE_PRE;
                end
            end
        endcase
    end

    // Sequencer state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= opi_pkg::MODE_WAIT;
            tone_reg         <= '0;
            rep_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                mode_reg  <= mode_next;
                tone_reg  <= tone_next;
                rep_reg   <= rep_next;
                count_reg <= count_next;
            end
            if (tick_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            out_valid_reg <= out_valid_next;
            out_real_reg  <= out_real_next;
            out_imag_reg  <= out_imag_next;
            taken_reg     <= taken_next;
            pre_reg       <= pre_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_real     = out_real_reg;
    assign out_imag     = out_imag_reg;
    assign sample_taken = taken_reg;
    assign in_preamble  = pre_reg;

    // A preamble tone is always emitted and carries no imaginary part.
    `OPI_ASSERT(a_pre_tone, !(result_valid_reg && pre_reg) || (out_valid_reg && out_imag_reg == '0))
    // A sample is popped exactly when a data sample is emitted.
    `OPI_ASSERT(a_taken_data, !result_valid_reg || (taken_reg == (out_valid_reg && !pre_reg)))
    // A tick taken while waiting emits nothing.
    `OPI_ASSERT_NEXT(a_wait_silent, tick_fire && mode_reg == opi_pkg::MODE_WAIT, !out_valid_reg)

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the OFDM preamble inserter with a frame-tracking scoreboard.
module testbench;

    localparam int SW          = 16;
    localparam int TONES_MAX   = 64;
    localparam int CYCLE_LIMIT = 400000;

    // One result item as it leaves the block.
    typedef struct packed {
        logic          valid;
        logic [SW-1:0] re;
        logic [SW-1:0] im;
        logic          taken;
        logic          preamble;
    } emit_t;

    // Tracks the sequencer and predicts the result item of every accepted tick.
    class frame_tracker;
        opi_pkg::mode_t                mode;
        logic [5:0]                    tone;
        logic [3:0]                    rep;
        logic [opi_pkg::FRAME_W-1:0]   count;
        logic [opi_pkg::NSUB_W-1:0]    num_sub;
        logic [opi_pkg::REP_W-1:0]     rep_cfg;
        logic [opi_pkg::FRAME_W-1:0]   frame_len;
        logic [63:0]                   pilot_bits;
        logic [63:0]                   sign_bits;
        logic [opi_pkg::AMP_W-1:0]     amp;
        emit_t                         outputs_due[$];
        int                            mismatches;

        function new();
            mode       = opi_pkg::MODE_WAIT;
            tone       = '0;
            rep        = '0;
            count      = '0;
            num_sub    = 7'd64;
            rep_cfg    = 5'd1;
            frame_len  = 16'd480;
            pilot_bits = '0;
            sign_bits  = '0;
            amp        = 15'd8192;
            mismatches = 0;
        endfunction

        // Mirror a register write; narrow registers keep only their low bits.
        function void write_reg(logic [opi_pkg::CFG_IDX_W-1:0] idx,
                                logic [opi_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                opi_pkg::CFG_NUM_SUB:    num_sub    = value[opi_pkg::NSUB_W-1:0];
                opi_pkg::CFG_REPEAT:     rep_cfg    = value[opi_pkg::REP_W-1:0];
                opi_pkg::CFG_FRAME:      frame_len  = value[opi_pkg::FRAME_W-1:0];
                opi_pkg::CFG_PILOT_MASK: pilot_bits = value;
                opi_pkg::CFG_SIGN_MASK:  sign_bits  = value;
                opi_pkg::CFG_AMPLITUDE:  amp        = value[opi_pkg::AMP_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the sequencer by one tick and queue the item it must produce.
        function void note_tick(logic present, logic second, logic [SW-1:0] s_re,
                                logic [SW-1:0] s_im);
            emit_t e;
            int    n_eff;
            int    r_eff;
            int    f_eff;
            e     = '0;
            n_eff = (num_sub == 0) ? 1 : ((num_sub > TONES_MAX) ? TONES_MAX : int'(num_sub));
            r_eff = (rep_cfg == 0) ? 1
                  : ((rep_cfg > opi_pkg::MAX_REPEAT) ? opi_pkg::MAX_REPEAT : int'(rep_cfg));
            f_eff = (frame_len == 0) ? 1 : int'(frame_len);
            case (mode)
                opi_pkg::MODE_PRE: begin
                    e.valid    = 1'b1;
                    e.preamble = 1'b1;
                    if (pilot_bits[tone])
                        e.re = sign_bits[tone] ? SW'(-int'(amp)) : SW'(amp);
                    // The end tests use greater-or-equal, so a shrunken size ends at once.
                    if (int'(tone) + 1 >= n_eff) begin
                        tone = '0;
                        if (int'(rep) + 1 >= r_eff) begin
                            rep   = '0;
                            count = '0;
                            mode  = opi_pkg::MODE_DATA;
                        end
                        else
                        begin
                            rep = rep + 1'b1;
                        end
                    end
                    else
                    begin
                        tone = tone + 1'b1;
                    end
                end
                opi_pkg::MODE_DATA: begin
                    if (present) begin
                        e.valid = 1'b1;
                        e.taken = 1'b1;
                        e.re    = s_re;
                        e.im    = s_im;
                        count   = count + 1'b1;
                        if (int'(count) >= f_eff) begin
                            count = '0;
                            tone  = '0;
                            rep   = '0;
                            mode  = second ? opi_pkg::MODE_PRE : opi_pkg::MODE_WAIT;
                        end
                    end
                end
                default: begin
                    mode = opi_pkg::MODE_WAIT;
                    if (present) begin
                        tone = '0;
                        rep  = '0;
                        mode = opi_pkg::MODE_PRE;
                    end
                end
            endcase
            outputs_due.push_back(e);
        endfunction

        // Compare an accepted result item with the oldest prediction, field by field.
        task check_output(emit_t got);
            emit_t want;
            if (outputs_due.size() == 0) begin
                flag_mismatch("result item with no prediction", '0, '0);
                return;
            end
            want = outputs_due[0];
            outputs_due.delete(0);
            if (got.valid !== want.valid)
                flag_mismatch("out_valid", SW'(got.valid), SW'(want.valid));
            if (got.re !== want.re)
                flag_mismatch("out_real", got.re, want.re);
            if (got.im !== want.im)
                flag_mismatch("out_imag", got.im, want.im);
            if (got.taken !== want.taken)
                flag_mismatch("sample_taken", SW'(got.taken), SW'(want.taken));
            if (got.preamble !== want.preamble)
                flag_mismatch("in_preamble", SW'(got.preamble), SW'(want.preamble));
        endtask

        task flag_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] want);
            mismatches++;
            $display("%0t: bad %s: got %h, predicted %h", $realtime, what, got, want);
        endtask
    endclass

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               cfg_we         = 1'b0;
    logic [opi_pkg::CFG_IDX_W-1:0]      cfg_index      = opi_pkg::CFG_NUM_SUB;
    logic [opi_pkg::CFG_DATA_W-1:0]     cfg_data       = '0;
    logic                               tick_valid     = 1'b0;
    logic                               tick_stall;
    logic                               sample_present = 1'b0;
    logic                               second_present = 1'b0;
    logic signed [SW-1:0]               sample_real    = '0;
    logic signed [SW-1:0]               sample_imag    = '0;
    logic                               result_valid;
    logic                               result_stall   = 1'b0;
    logic                               out_valid;
    logic signed [SW-1:0]               out_real;
    logic signed [SW-1:0]               out_imag;
    logic                               sample_taken;
    logic                               in_preamble;

    frame_tracker tracker = new();
    emit_t        seen;
    int           burst_left  = 0;
    int           cycle_count = 0;
    logic [1:0]   stall_style = 2'd0;
    int           style_left  = 0;

    ofdm_preamble_inserter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tick_valid     (tick_valid),
        .tick_stall     (tick_stall),
        .sample_present (sample_present),
        .second_present (second_present),
        .sample_real    (sample_real),
        .sample_imag    (sample_imag),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_valid      (out_valid),
        .out_real       (out_real),
        .out_imag       (out_imag),
        .sample_taken   (sample_taken),
        .in_preamble    (in_preamble)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both handshakes, then pick the next receiver stall from the current style.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (tick_valid && !tick_stall)
                tracker.note_tick(sample_present, second_present, sample_real, sample_imag);
            if (result_valid && !result_stall) begin
                seen = {out_valid, out_real, out_imag, sample_taken, in_preamble};
                tracker.check_output(seen);
            end
        end
        if (style_left == 0) begin
            stall_style <= 2'($urandom_range(0, 3));
            style_left  <= $urandom_range(16, 96);
        end
        else
        begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            2'd0:    result_stall <= 1'b0;
            2'd1:    result_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ~result_stall;
        endcase
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ofdm_preamble_inserter: mismatch");
            $finish;
        end
    end

    // Offer one tick and hold it until accepted; gaps fall between bursts.
    task send_item(logic present, logic second, logic [SW-1:0] s_re, logic [SW-1:0] s_im);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick_valid     <= 1'b1;
        sample_present <= present;
        second_present <= second;
        sample_real    <= s_re;
        sample_imag    <= s_im;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
    endtask

    // Mostly random samples, with the extremes now and then.
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SW'($urandom);
        endcase
    endfunction

    // Ticks from a queue that is mostly fed, sometimes empty, rarely inconsistent.
    task run_random(int num_items);
        int   roll;
        logic present;
        logic second;
        for (int i = 0; i < num_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                present = 1'b1;
                second  = 1'($urandom_range(0, 1));
            end
            else if (roll < 95) begin
                present = 1'b0;
                second  = 1'b0;
            end
            else
            begin
                present = 1'b0;
                second  = 1'b1;
            end
            send_item(present, second, pick_sample(), pick_sample());
        end
    endtask

    // Stop sending and wait until every predicted item has come out.
    task finish_phase();
        tick_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (tracker.outputs_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(logic [opi_pkg::CFG_IDX_W-1:0] idx, logic [opi_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
    endtask

    // Write all six registers; narrow ones get random junk in their unused high bits.
    task configure(logic [opi_pkg::NSUB_W-1:0] n, logic [opi_pkg::REP_W-1:0] r,
                   logic [opi_pkg::FRAME_W-1:0] f, logic [opi_pkg::AMP_W-1:0] a,
                   logic [63:0] pm, logic [63:0] sm);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(opi_pkg::CFG_NUM_SUB, {junk[63:opi_pkg::NSUB_W], n});
        write_reg(opi_pkg::CFG_REPEAT, {junk[63:opi_pkg::REP_W], r});
        write_reg(opi_pkg::CFG_FRAME, {junk[63:opi_pkg::FRAME_W], f});
        write_reg(opi_pkg::CFG_PILOT_MASK, pm);
        write_reg(opi_pkg::CFG_SIGN_MASK, sm);
        write_reg(opi_pkg::CFG_AMPLITUDE, {junk[63:opi_pkg::AMP_W], a});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] rand_pm;
        logic [63:0] rand_sm;
        logic [14:0] rand_amp;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Default register values straight out of reset.
        run_random(200);
        finish_phase();

        // Directed: three tones sent twice, two-sample frames, max amplitude.
        configure(7'd3, 5'd2, 16'd2, 15'd32767, 64'hFFFF_FFFF_FFFF_FFFD, 64'h4);
        send_item(1'b0, 1'b0, 16'h0000, 16'h0000);
        send_item(1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 1'b0, 16'h7FFF, 16'h8000);
        for (int i = 0; i < 6; i++)
            send_item(1'($urandom_range(0, 1)), 1'b0, pick_sample(), pick_sample());
        // Data tick with an empty queue holds the state.
        send_item(1'b0, 1'b1, 16'h1234, 16'h5678);
        send_item(1'b1, 1'b0, 16'h8000, 16'h7FFF);
        // Frame ends with another sample queued: straight back to the preamble.
        send_item(1'b1, 1'b1, 16'h7FFF, 16'h8000);
        for (int i = 0; i < 6; i++)
            send_item(1'b1, 1'b1, pick_sample(), pick_sample());
        send_item(1'b1, 1'b0, 16'h0000, 16'h0000);
        // Frame ends with the queue drained: back to waiting.
        send_item(1'b1, 1'b0, 16'hFFFF, 16'h0001);
        send_item(1'b1, 1'b1, 16'h0001, 16'hFFFF);
        finish_phase();

        // Random phases; the sequencer state carries over across register changes.
        for (int p = 0; p < 14; p++) begin
            rand_pm  = {$urandom, $urandom};
            rand_sm  = {$urandom, $urandom};
            rand_amp = 15'($urandom_range(0, 32767));
            case (p)
                0: configure(7'd1, 5'd1, 16'd1, 15'd32767, '1, '1);
                1: configure(7'd64, 5'd16, 16'd2, 15'd0, '1, '0);
                2: configure(7'd0, 5'd0, 16'd0, rand_amp, rand_pm, rand_sm);
                3: configure(7'd127, 5'd31, 16'd3, rand_amp, rand_pm, rand_sm);
                4: configure(7'd2, 5'd2, 16'd65535, rand_amp, rand_pm, rand_sm);
                5: configure(7'd4, 5'd1, 16'd5, 15'd1, rand_pm, rand_sm);
                default: configure(($urandom_range(0, 7) == 0) ? 7'd64
                                       : 7'($urandom_range(1, 12)),
                                   5'($urandom_range(1, 4)), 16'($urandom_range(1, 16)),
                                   rand_amp, rand_pm, rand_sm);
            endcase
            run_random((p == 4) ? 150 : 100);
            finish_phase();
        end

        repeat (6) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outputs_due.size() == 0)
            $display("ofdm_preamble_inserter: match");
        else
            $display("ofdm_preamble_inserter: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/opi_pkg.sv
hw/rtl/opi_cfg_regs.sv
hw/rtl/ofdm_preamble_inserter.sv
sim/testbench.sv
